FILE: sv/bblp_pkg.sv
// Shared types, constants and a helper function for the box blur line pass.
package bblp_pkg;

	localparam int PIX_W      = 16;
	localparam int RAD_W      = 5;
	localparam int DIAM_W     = RAD_W + 1;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 14;
	localparam int POS_W      = 13;
	localparam int QUOT_W     = 6;
	localparam int BIT_W      = 3;
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int MAX_LINE   = 4096;

	localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(12);
	localparam logic [POS_W-1:0] LINE_LAST_POS = POS_W'(MAX_LINE - 1);
	localparam logic [BIT_W-1:0] DIV_FIRST_BIT = BIT_W'(7);
	localparam logic [BIT_W-1:0] DIV_LAST_BIT  = BIT_W'(2);

	// Channel lanes: index 2 is red, 1 is green, 0 is blue.
	typedef logic [2:0][CH_W-1:0] chan_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SLIDE,
		ST_DIV,
		ST_OUT
	} bblp_state_t;

	typedef struct packed {
		logic accept;
		logic slide;
		logic div_step;
		logic advance;
		logic finish;
	} bblp_cmd_t;

	typedef struct packed {
		logic emit;
		logic more;
		logic div_last;
	} bblp_stat_t;

	// Widens each RGB565 channel to 8 bits by replicating its top bits.
	function automatic chan_vec_t unpack(input logic [PIX_W-1:0] p);
		chan_vec_t c;
		c[2] = {p[15:11], p[15:13]};
		c[1] = {p[10:5], p[10:9]};
		c[0] = {p[4:0], p[4:2]};
		return c;
	endfunction

endpackage

FILE: sv/bblp_in_if.sv
// Valid/ready channel that carries one input pixel word.
interface bblp_in_if;
	logic                        valid;
	logic                        ready;
	logic [bblp_pkg::PIX_W-1:0]  in_pixel;
	logic                        in_last;

	modport source (output valid, in_pixel, in_last, input ready);
	modport sink (input valid, in_pixel, in_last, output ready);
endinterface

FILE: sv/bblp_out_if.sv
// Valid/ready channel that carries one blurred pixel word.
interface bblp_out_if;
	logic                        valid;
	logic                        ready;
	logic [bblp_pkg::PIX_W-1:0]  out_pixel;
	logic                        out_last;

	modport source (output valid, out_pixel, out_last, input ready);
	modport sink (input valid, out_pixel, out_last, output ready);
endinterface

FILE: sv/box_blur_line_pass.sv
// Top level of the box blur line pass: RGB565 running-sum blur over one line.
//
//  port      dir   payload               meaning
//  line_px   sink  in_pixel, in_last     one pixel word of the line, last flag on final pixel
//  blur_px   src   out_pixel, out_last   one blurred pixel word, last flag on final result
//  cfg_*     in    cfg_data (5 bits)     window radius, write while idle; clears the line
//
// A pixel that yields no result passes through accept, ring read and slide.
// A result passes through ring read, slide, six steps of the shift-subtract divider
// (one quotient bit per step) and the output state, which holds through output stalls.
// The end-of-line flush runs radius more positions: each passes through ring read and
// slide, and one that gives a result also through the divider and the output state.
// Reset restores radius 12 and starts a new line; the ring needs no clearing.
// While a result waits on blur_px.ready, line_px.ready stays low.
module box_blur_line_pass (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bblp_pkg::RAD_W-1:0]  cfg_data,
	bblp_in_if.sink                     line_px,
	bblp_out_if.source                  blur_px
);

	bblp_pkg::bblp_cmd_t  cmd;
	bblp_pkg::bblp_stat_t stat;

	bblp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (line_px.valid),
		.in_ready  (line_px.ready),
		.out_valid (blur_px.valid),
		.out_ready (blur_px.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bblp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_pixel  (line_px.in_pixel),
		.in_last   (line_px.in_last),
		.out_pixel (blur_px.out_pixel),
		.out_last  (blur_px.out_last),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: sv/bblp_ram.sv
// Generic simple dual-port RAM with registered read data.
module bblp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/bblp_ctrl.sv
// Controller state machine that sequences ring read, window slide, divide and output.
module bblp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  bblp_pkg::bblp_stat_t  stat,
	output bblp_pkg::bblp_cmd_t   cmd
);

	bblp_pkg::bblp_state_t state_q;
	bblp_pkg::bblp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bblp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bblp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bblp_pkg::ST_READ;
				end
			end
			bblp_pkg::ST_READ: begin
				state_d = bblp_pkg::ST_SLIDE;
			end
			bblp_pkg::ST_SLIDE: begin
				if (stat.emit) begin
					state_d = bblp_pkg::ST_DIV;
				end else if (stat.more) begin
					state_d = bblp_pkg::ST_READ;
				end else begin
					state_d = bblp_pkg::ST_IDLE;
				end
			end
			bblp_pkg::ST_DIV: begin
				if (stat.div_last) begin
					state_d = bblp_pkg::ST_OUT;
				end
			end
			bblp_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = stat.more ? bblp_pkg::ST_READ : bblp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bblp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			bblp_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			bblp_pkg::ST_READ: begin
			end
			bblp_pkg::ST_SLIDE: begin
				cmd.slide   = 1'b1;
				cmd.advance = !stat.emit && stat.more;
				cmd.finish  = !stat.emit && !stat.more;
			end
			bblp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			bblp_pkg::ST_OUT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready && stat.more;
				cmd.finish  = out_ready && !stat.more;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/bblp_dpath.sv
// Datapath: window ring, running channel sums, shift-subtract divider and output word.
module bblp_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bblp_pkg::RAD_W-1:0]     cfg_data,
	input  logic [bblp_pkg::PIX_W-1:0]     in_pixel,
	input  logic                           in_last,
	output logic [bblp_pkg::PIX_W-1:0]     out_pixel,
	output logic                           out_last,
	input  bblp_pkg::bblp_cmd_t            cmd,
	output bblp_pkg::bblp_stat_t           stat
);

	logic [bblp_pkg::RAD_W-1:0]   radius_q;
	logic [bblp_pkg::POS_W-1:0]   seen_q;
	logic                         flush_q;
	logic [bblp_pkg::POS_W-1:0]   pos_q;
	logic [bblp_pkg::POS_W-1:0]   end_q;
	logic [bblp_pkg::PIX_W-1:0]   pix_q;
	logic [bblp_pkg::PIX_W-1:0]   first_q;
	logic [bblp_pkg::BIT_W-1:0]   bit_q;
	logic [2:0][bblp_pkg::SUM_W-1:0]  sum_q;
	logic [2:0][bblp_pkg::SUM_W-1:0]  rem_q;
	logic [2:0][bblp_pkg::QUOT_W-1:0] quot_q;
	logic [bblp_pkg::PIX_W-1:0]   out_pixel_q;
	logic                         out_last_q;

	logic [bblp_pkg::DIAM_W-1:0]  diam;
	logic [bblp_pkg::RING_AW-1:0] ring_raddr;
	logic [bblp_pkg::PIX_W-1:0]   ring_rdata;
	logic [bblp_pkg::PIX_W-1:0]   sub_pix;
	bblp_pkg::chan_vec_t          add_ch;
	bblp_pkg::chan_vec_t          sub_ch;
	logic [2:0][bblp_pkg::SUM_W-1:0]  sum_d;
	logic [bblp_pkg::SUM_W-1:0]   div_shift;
	logic [2:0]                   div_ge;
	logic [2:0][bblp_pkg::SUM_W-1:0]  rem_d;
	logic [2:0][bblp_pkg::QUOT_W-1:0] quot_d;

	assign diam = {radius_q, 1'b1};

	// The leaving pixel sits 2*radius+1 places behind the current position.
	assign ring_raddr = pos_q[bblp_pkg::RING_AW-1:0] - bblp_pkg::RING_AW'(diam);

	bblp_ram #(
		.WIDTH (bblp_pkg::PIX_W),
		.DEPTH (bblp_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (seen_q[bblp_pkg::RING_AW-1:0]),
		.wdata (in_pixel),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Positions left of the line read as its first pixel.
	assign sub_pix = (pos_q <= bblp_pkg::POS_W'(diam)) ? first_q : ring_rdata;
	assign add_ch  = bblp_pkg::unpack(pix_q);
	assign sub_ch  = bblp_pkg::unpack(sub_pix);
	assign div_shift = bblp_pkg::SUM_W'(diam) << bit_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if (pos_q == '0) begin
				sum_d[ch] = bblp_pkg::SUM_W'(add_ch[ch]) * bblp_pkg::SUM_W'(diam);
			end else begin
				sum_d[ch] = sum_q[ch] + bblp_pkg::SUM_W'(add_ch[ch])
					- bblp_pkg::SUM_W'(sub_ch[ch]);
			end
			div_ge[ch] = rem_q[ch] >= div_shift;
			rem_d[ch]  = div_ge[ch] ? rem_q[ch] - div_shift : rem_q[ch];
			quot_d[ch] = {quot_q[ch][bblp_pkg::QUOT_W-2:0], div_ge[ch]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bblp_pkg::RADIUS_RESET;
			seen_q   <= '0;
			flush_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
				seen_q   <= '0;
			end else if (cmd.finish) begin
				seen_q <= flush_q ? '0 : seen_q + 1'b1;
			end
			if (cmd.accept) begin
				flush_q <= in_last || (seen_q >= bblp_pkg::LINE_LAST_POS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= in_pixel;
			pos_q <= seen_q;
			end_q <= seen_q + bblp_pkg::POS_W'(radius_q);
			if (seen_q == '0) begin
				first_q <= in_pixel;
			end
		end else if (cmd.advance) begin
			pos_q <= pos_q + 1'b1;
		end
		if (cmd.slide) begin
			sum_q <= sum_d;
			rem_q <= sum_d;
			bit_q <= bblp_pkg::DIV_FIRST_BIT;
		end else if (cmd.div_step) begin
			rem_q  <= rem_d;
			quot_q <= quot_d;
			bit_q  <= bit_q - 1'b1;
			if (bit_q == bblp_pkg::DIV_LAST_BIT) begin
				out_pixel_q <= {quot_d[2][bblp_pkg::QUOT_W-1:1], quot_d[1],
					quot_d[0][bblp_pkg::QUOT_W-1:1]};
				out_last_q  <= flush_q && (pos_q == end_q);
			end
		end
	end

	assign stat.emit     = pos_q >= bblp_pkg::POS_W'(radius_q);
	assign stat.more     = flush_q && (pos_q != end_q);
	assign stat.div_last = bit_q == bblp_pkg::DIV_LAST_BIT;

	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

endmodule
